// ----- hw/rtl/zrbe_pkg.sv -----
// Shared types and constants for the zero-run bitmap encoder.
// Used by the controller, the datapath and the top level; no dependencies.

package zrbe_pkg;

   // Fixed geometry of the input and result items
   localparam int CHUNK_BITS      = 64;
   localparam int VECTOR_BITS_DEF = 8192;
   localparam int CNT_W           = $clog2(CHUNK_BITS);
   localparam int RUN_W           = 14;
   localparam int SZ_W            = 4;
   localparam int VAL_W           = 13;
   localparam int CODE_W          = 27;
   localparam int LEN_W           = 5;
   localparam int TOTAL_W         = 14;
   localparam int RSP_DATA_W      = 48;
   localparam int RSP_USER_W      = 2;

   // Zero count saturates here, so sz stays at or below 13
   localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(16382);

   // Controller to datapath commands
   typedef struct packed {
      logic load;    // take the input transaction into the chunk register
      logic scan;    // examine one chunk bit this cycle when step_ok allows
      logic flush;   // send the closing result of the chunk
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic step_ok;    // scan step can advance this cycle
      logic cnt_last;   // bit under scan is the top bit of the chunk
      logic out_free;   // output register can take a result this cycle
   } status_type;

endpackage

// ----- hw/rtl/zrbe_ctrl.sv -----
// Sequencer for the zero-run bitmap encoder: idle, bit scan, closing flush.
// Depends on zrbe_pkg for the command and status structs.

module zrbe_ctrl
   import zrbe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.step_ok && status.cnt_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            cmd.flush = 1'b1;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/zrbe_datapath.sv -----
// Datapath of the zero-run bitmap encoder: chunk shifter, zero-run tracking,
// codeword build, overflow check, one-deep pending result and output register.
// Depends on zrbe_pkg; driven by zrbe_ctrl commands.

module zrbe_datapath
   import zrbe_pkg::*;
#(
   parameter int VECTOR_BITS = VECTOR_BITS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [CHUNK_BITS-1:0] chunk_bits,
   input  logic                  final_chunk,
   input  logic                  csr_valid,
   input  logic                  csr_data,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [CODE_W-1:0]     code_bits,
   output logic [LEN_W-1:0]      code_length,
   output logic                  chunk_end,
   output logic                  vector_done,
   output logic                  overflow,
   output logic [TOTAL_W-1:0]    total_bits
);

   localparam int BE_W = $clog2(VECTOR_BITS + 1);
   localparam int TW   = (BE_W > TOTAL_W) ? BE_W : TOTAL_W;

   // Scan state
   logic [CHUNK_BITS-1:0] chunk_ff, chunk_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  final_ff, final_in;
   logic                  mode_ff, mode_in;

   // Vector state: zero run with its size class and offset kept alongside
   logic [RUN_W-1:0]      run_ff, run_in;
   logic [SZ_W-1:0]       sz_ff, sz_in;
   logic [VAL_W-1:0]      val_ff, val_in;
   logic [BE_W-1:0]       be_ff, be_in;
   logic                  ovf_ff, ovf_in;

   // Pending result, held until it is known whether it closes the chunk
   logic                  pend_valid_ff, pend_valid_in;
   logic [CODE_W-1:0]     pend_code_ff, pend_code_in;
   logic [LEN_W-1:0]      pend_len_ff, pend_len_in;
   logic [TOTAL_W-1:0]    pend_total_ff, pend_total_in;

   // Output register
   logic                  out_valid_ff, out_valid_in;
   logic [CODE_W-1:0]     out_code_ff, out_code_in;
   logic [LEN_W-1:0]      out_len_ff, out_len_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_done_ff, out_done_in;
   logic                  out_ovf_ff, out_ovf_in;
   logic [TOTAL_W-1:0]    out_total_ff, out_total_in;

   // Codeword of the current bit
   logic                  cur_bit;
   logic [VAL_W-1:0]      val_mask;
   logic [CODE_W-1:0]     cw_code;
   logic [LEN_W-1:0]      cw_len;
   logic [BE_W:0]         be_sum;
   logic                  fits;
   logic                  emit_try;
   logic                  out_free;
   logic                  step_ok;
   logic [TW-1:0]         be_new_ext;
   logic [TW-1:0]         be_cur_ext;

   always_comb begin
      cur_bit    = chunk_ff[0];
      val_mask   = VAL_W'((RUN_W'(1) << sz_ff) - RUN_W'(1));
      cw_code    = (CODE_W'(1) << sz_ff) | (CODE_W'(val_ff) << (sz_ff + SZ_W'(1)));
      cw_len     = {sz_ff, 1'b1};
      be_sum     = {1'b0, be_ff} + (BE_W + 1)'(cw_len);
      fits       = be_sum <= (BE_W + 1)'(VECTOR_BITS);
      emit_try   = cur_bit && !ovf_ff;
      out_free   = !out_valid_ff || rsp_tready;
      step_ok    = !(emit_try && fits && pend_valid_ff) || out_free;
      be_new_ext = TW'(be_sum[BE_W-1:0]);
      be_cur_ext = TW'(be_ff);
   end

   assign status.step_ok  = step_ok;
   assign status.cnt_last = (cnt_ff == CNT_W'(CHUNK_BITS - 1));
   assign status.out_free = out_free;

   // Next-state logic
   always_comb begin
      chunk_in      = chunk_ff;
      cnt_in        = cnt_ff;
      final_in      = final_ff;
      mode_in       = mode_ff;
      run_in        = run_ff;
      sz_in         = sz_ff;
      val_in        = val_ff;
      be_in         = be_ff;
      ovf_in        = ovf_ff;
      pend_valid_in = pend_valid_ff;
      pend_code_in  = pend_code_ff;
      pend_len_in   = pend_len_ff;
      pend_total_in = pend_total_ff;
      out_valid_in  = out_valid_ff;
      out_code_in   = out_code_ff;
      out_len_in    = out_len_ff;
      out_last_in   = out_last_ff;
      out_done_in   = out_done_ff;
      out_ovf_in    = out_ovf_ff;
      out_total_in  = out_total_ff;

      // downstream takes the result
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      // config write
      if (csr_valid) begin
         mode_in = csr_data;
      end

      // new chunk
      if (cmd.load) begin
         chunk_in = mode_ff ? ~chunk_bits : chunk_bits;
         final_in = final_chunk;
         cnt_in   = '0;
      end

      // one chunk bit per cycle, unless step_ok holds the scan
      if (cmd.scan && step_ok) begin
         chunk_in = chunk_ff >> 1;
         cnt_in   = cnt_ff + CNT_W'(1);
         if (!cur_bit) begin
            if (run_ff < RUN_MAX) begin
               run_in = run_ff + RUN_W'(1);
               if (val_ff == val_mask) begin
                  sz_in  = sz_ff + SZ_W'(1);
                  val_in = '0;
               end else begin
                  val_in = val_ff + VAL_W'(1);
               end
            end
         end else begin
            run_in = '0;
            sz_in  = '0;
            val_in = '0;
            if (emit_try) begin
               if (!fits) begin
                  ovf_in = 1'b1;
               end else begin
                  be_in = be_sum[BE_W-1:0];
                  // an earlier codeword is now known not to close the chunk
                  if (pend_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_code_in  = pend_code_ff;
                     out_len_in   = pend_len_ff;
                     out_last_in  = 1'b0;
                     out_done_in  = 1'b0;
                     out_ovf_in   = 1'b0;
                     out_total_in = pend_total_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_code_in  = cw_code;
                  pend_len_in   = cw_len;
                  pend_total_in = be_new_ext[TOTAL_W-1:0];
               end
            end
         end
      end

      // closing result: last codeword, or a marker when none was sent
      if (cmd.flush && out_free) begin
         out_valid_in  = 1'b1;
         out_code_in   = pend_valid_ff ? pend_code_ff : '0;
         out_len_in    = pend_valid_ff ? pend_len_ff : '0;
         out_total_in  = pend_valid_ff ? pend_total_ff : be_cur_ext[TOTAL_W-1:0];
         out_last_in   = 1'b1;
         out_done_in   = final_ff;
         out_ovf_in    = ovf_ff;
         pend_valid_in = 1'b0;
         if (final_ff) begin
            run_in = '0;
            sz_in  = '0;
            val_in = '0;
            be_in  = '0;
            ovf_in = 1'b0;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         mode_ff       <= 1'b0;
         run_ff        <= '0;
         sz_ff         <= '0;
         val_ff        <= '0;
         be_ff         <= '0;
         ovf_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         mode_ff       <= mode_in;
         run_ff        <= run_in;
         sz_ff         <= sz_in;
         val_ff        <= val_in;
         be_ff         <= be_in;
         ovf_ff        <= ovf_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      chunk_ff      <= chunk_in;
      final_ff      <= final_in;
      pend_code_ff  <= pend_code_in;
      pend_len_ff   <= pend_len_in;
      pend_total_ff <= pend_total_in;
      out_code_ff   <= out_code_in;
      out_len_ff    <= out_len_in;
      out_last_ff   <= out_last_in;
      out_done_ff   <= out_done_in;
      out_ovf_ff    <= out_ovf_in;
      out_total_ff  <= out_total_in;
   end

   assign rsp_tvalid  = out_valid_ff;
   assign code_bits   = out_code_ff;
   assign code_length = out_len_ff;
   assign chunk_end   = out_last_ff;
   assign vector_done = out_done_ff;
   assign overflow    = out_ovf_ff;
   assign total_bits  = out_total_ff;

endmodule

// ----- hw/rtl/zero_run_bitmap_encoder_top.sv -----
// Top level of the zero-run bitmap encoder.
// Joins zrbe_ctrl and zrbe_datapath; depends on zrbe_pkg.
//
// Usage:
//  - req channel: one transaction per 64-bit chunk of the vector, lowest
//    position in bit 0; req_tlast marks the final chunk of the vector.
//  - rsp channel: one transaction per codeword (zero-run code, bit 0 sent
//    first), or a single marker with length 0 when a chunk sends none.
//    rsp_tlast closes each chunk; tuser carries vector end and overflow.
//  - csr channel: writes complement_mode; always ready, write only while idle.
// Timing: a chunk is scanned one bit per cycle by the datapath shifter when
// the scan is not stalled. A chunk is accepted, all its bits are scanned and
// the closing flush is sent before the next chunk is accepted. A codeword is
// held until the next codeword of the chunk is taken by the scan or the flush
// comes, and then goes to the output register; the closing result at the flush.
// Stall: a codeword waits in a one-deep pending slot, so the scan halts
// only when a new codeword finds both that slot and the output register
// full; results are never dropped.
// Reset: clears the zero run, emitted-bit count, overflow flag and mode.

module zero_run_bitmap_encoder_top
   import zrbe_pkg::*;
#(
   parameter int VECTOR_BITS = VECTOR_BITS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   // tdata: chunk_bits[63:0]
   input  logic [CHUNK_BITS-1:0]  req_tdata,
   input  logic                   req_tlast,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // tdata: code_bits[26:0], code_length[31:27], total_bits[45:32], zero pad
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // tuser: vector_done[0], overflow[1]
   output logic [RSP_USER_W-1:0]  rsp_tuser,
   output logic                   rsp_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_data
);

   cmd_type            cmd;
   status_type         status;
   logic [CODE_W-1:0]  code_bits;
   logic [LEN_W-1:0]   code_length;
   logic               vector_done;
   logic               overflow;
   logic [TOTAL_W-1:0] total_bits;

   assign csr_ready = 1'b1;

   zrbe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   zrbe_datapath #(
      .VECTOR_BITS (VECTOR_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .chunk_bits  (req_tdata),
      .final_chunk (req_tlast),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .code_bits   (code_bits),
      .code_length (code_length),
      .chunk_end   (rsp_tlast),
      .vector_done (vector_done),
      .overflow    (overflow),
      .total_bits  (total_bits)
   );

   // Pack result fields
   assign rsp_tdata = {(RSP_DATA_W - CODE_W - LEN_W - TOTAL_W)'(0),
                       total_bits, code_length, code_bits};
   assign rsp_tuser = {overflow, vector_done};

endmodule

// ----- hw/rtl/zrbe_checker.sv -----
// Port-level checks for the zero-run bitmap encoder.
// Bound to zero_run_bitmap_encoder_top; depends on zrbe_pkg.

module zrbe_checker
   import zrbe_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser,
   input logic                  rsp_tlast,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Codeword length is odd, or zero for a marker that closes the chunk
   a_len_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[27] ||
         (rsp_tdata[31:27] == '0 && rsp_tdata[26:0] == '0 && rsp_tlast))
      else $error("bad codeword length");

   // Vector end and overflow are only reported on the closing result
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[0] || rsp_tuser[1]) |-> rsp_tlast)
      else $error("vector flags off the closing result");

   // One chunk at a time: no new acceptance right after one
   a_one_chunk: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("chunk accepted while busy");

endmodule

bind zero_run_bitmap_encoder_top zrbe_checker u_zrbe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
